// File: hw/rtl/sbvs_pkg.sv
// ----------------------------------------------------------------------------
// sbvs_pkg
// Shared types and constants for the shunt bank voltage stepper.
// ----------------------------------------------------------------------------
package sbvs_pkg;

  // default sizing
  localparam int DEF_NUM_SHUNTS = 8;
  localparam int DEF_VOLT_BITS  = 16;

  // fixed field widths
  localparam int MASK_BITS = 8;
  localparam int BAND_W    = 14;
  localparam int SECT_W    = 8;
  localparam int TIME_W    = 32;
  localparam int DELAY_W   = 16;
  localparam int ACTIVE_W  = 4;
  localparam int KIND_W    = 2;
  localparam int SHUNT_W   = 3;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // register reset values
  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd10;

  // item actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  // register indexes (paddr[2])
  localparam logic REG_STEP_DELAY    = 1'b0;
  localparam logic REG_ACTIVE_SHUNTS = 1'b1;

  // step kinds
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // write one bank's settings
    logic start;   // latch evaluate beat, restart scan
    logic scan;    // test current bank, advance
    logic commit;  // update timers and section, write result
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_stop;  // bank found or scan exhausted
    logic out_free;   // result register can take a beat
  } dp_status_t;

endpackage

// File: hw/rtl/shunt_bank_voltage_stepper_core.sv
// ----------------------------------------------------------------------------
// shunt_bank_voltage_stepper_core
// Steps shunt bank sections to hold a node voltage inside each dead band.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration goes through the APB-style port: step_delay at 0x0,
//   active_shunts at 0x4. Write it only while the block is idle.
//   Input beats use in_valid/in_stall. A load beat (action 0) writes one
//   bank's settings and yields no result. An evaluate beat (action 1)
//   yields exactly one result beat on out_valid/out_stall. The scan tests
//   one bank per cycle, up to the chosen bank or the clamped active count,
//   and then the commit step updates the timers and writes the result.
//   One evaluate is in flight at a time; in_stall is high from acceptance
//   until the result is written into the output register.
//   If the receiver stalls, the result register holds its beat; a following
//   load beat is still taken, and a following evaluate waits in its commit
//   cycle until the register frees.
//   Reset idles both timers, clears the last step stamp, sets step_delay to
//   10 and active_shunts to 0. Bank tables hold nothing until loaded.
// ----------------------------------------------------------------------------
module shunt_bank_voltage_stepper_core
  import sbvs_pkg::*;
#(
  parameter int NUM_SHUNTS = DEF_NUM_SHUNTS,
  parameter int VOLT_BITS  = DEF_VOLT_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [SHUNT_W-1:0]   shunt_index,
  input  logic [SECT_W-1:0]    section_min,
  input  logic [SECT_W-1:0]    section_max,
  input  logic [SECT_W-1:0]    section_start,
  input  logic [BAND_W-1:0]    dead_band,
  input  logic                 is_reactor,
  input  logic [TIME_W-1:0]    time_now,
  input  logic [VOLT_BITS-1:0] voltage,
  input  logic [VOLT_BITS-1:0] voltage_ref,
  input  logic [MASK_BITS-1:0] running_mask,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KIND_W-1:0]    step_kind,
  output logic [SHUNT_W-1:0]   step_shunt,
  output logic [SECT_W-1:0]    new_section
);

  logic [DELAY_W-1:0]  step_delay;
  logic [ACTIVE_W-1:0] active_shunts;
  dp_cmd_t             cmd;
  dp_status_t          status;

  sbvs_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .step_delay    (step_delay),
    .active_shunts (active_shunts)
  );

  sbvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .cmd      (cmd),
    .status   (status)
  );

  sbvs_datapath #(
    .NUM_SHUNTS (NUM_SHUNTS),
    .VOLT_BITS  (VOLT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .shunt_index   (shunt_index),
    .section_min   (section_min),
    .section_max   (section_max),
    .section_start (section_start),
    .dead_band     (dead_band),
    .is_reactor    (is_reactor),
    .time_now      (time_now),
    .voltage       (voltage),
    .voltage_ref   (voltage_ref),
    .running_mask  (running_mask),
    .step_delay    (step_delay),
    .active_shunts (active_shunts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .step_kind     (step_kind),
    .step_shunt    (step_shunt),
    .new_section   (new_section)
  );

`ifndef SYNTHESIS
  // an evaluate beat blocks the input side for at least the next cycle
  a_eval_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (action == ACT_EVAL)) |=> in_stall)
    else $error("input not blocked after evaluate beat");

  // a load beat never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (action == ACT_LOAD)) |=> !$rose(out_valid))
    else $error("result appeared after load beat");

  // no reserved step code on a valid result
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (step_kind != KIND_RSVD))
    else $error("reserved step kind");

  // a no-step result carries zero bank and section
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (step_kind == KIND_NONE)) |-> ((step_shunt == '0) && (new_section == '0)))
    else $error("no-step result with nonzero payload");
`endif

endmodule

// File: hw/rtl/sbvs_regs.sv
// ----------------------------------------------------------------------------
// sbvs_regs
// APB-style configuration registers: step delay and active bank count.
// ----------------------------------------------------------------------------
module sbvs_regs
  import sbvs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  output logic [DELAY_W-1:0]  step_delay,
  output logic [ACTIVE_W-1:0] active_shunts
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_delay    <= DELAY_RESET;
      active_shunts <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_STEP_DELAY:    step_delay    <= pwdata[DELAY_W-1:0];
        REG_ACTIVE_SHUNTS: active_shunts <= pwdata[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[2])
      REG_STEP_DELAY:    prdata = PDATA_W'(step_delay);
      REG_ACTIVE_SHUNTS: prdata = PDATA_W'(active_shunts);
      default:           prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/sbvs_ctrl.sv
// ----------------------------------------------------------------------------
// sbvs_ctrl
// Sequencer: takes input beats, walks the bank scan, commits one result.
// ----------------------------------------------------------------------------
module sbvs_ctrl
  import sbvs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // commands
  always_comb begin
    cmd.load   = accept && (action == ACT_LOAD);
    cmd.start  = accept && (action == ACT_EVAL);
    cmd.scan   = (state == ST_SCAN);
    cmd.commit = (state == ST_STEP) && status.out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd.start) state_next = ST_SCAN;
      ST_SCAN: if (status.scan_stop) state_next = ST_STEP;
      ST_STEP: if (status.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/sbvs_datapath.sv
// ----------------------------------------------------------------------------
// sbvs_datapath
// Bank tables, one-bank-per-cycle scan, direction timers and result register.
// ----------------------------------------------------------------------------
module sbvs_datapath
  import sbvs_pkg::*;
#(
  parameter int NUM_SHUNTS = DEF_NUM_SHUNTS,
  parameter int VOLT_BITS  = DEF_VOLT_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic [SHUNT_W-1:0]   shunt_index,
  input  logic [SECT_W-1:0]    section_min,
  input  logic [SECT_W-1:0]    section_max,
  input  logic [SECT_W-1:0]    section_start,
  input  logic [BAND_W-1:0]    dead_band,
  input  logic                 is_reactor,
  input  logic [TIME_W-1:0]    time_now,
  input  logic [VOLT_BITS-1:0] voltage,
  input  logic [VOLT_BITS-1:0] voltage_ref,
  input  logic [MASK_BITS-1:0] running_mask,
  input  logic [DELAY_W-1:0]   step_delay,
  input  logic [ACTIVE_W-1:0]  active_shunts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KIND_W-1:0]    step_kind,
  output logic [SHUNT_W-1:0]   step_shunt,
  output logic [SECT_W-1:0]    new_section
);

  localparam int IDX_W = (NUM_SHUNTS > 1) ? $clog2(NUM_SHUNTS) : 1;
  localparam int CNT_W = $clog2(NUM_SHUNTS + 1);
  localparam int CMP_W = ((VOLT_BITS > BAND_W) ? VOLT_BITS : BAND_W) + 1;

  // bank tables
  logic [SECT_W-1:0]     section_count [NUM_SHUNTS];
  logic [SECT_W-1:0]     min_table     [NUM_SHUNTS];
  logic [SECT_W-1:0]     max_table     [NUM_SHUNTS];
  logic [BAND_W-1:0]     band_table    [NUM_SHUNTS];
  logic [NUM_SHUNTS-1:0] reactor_flags;

  // latched evaluate beat
  logic [TIME_W-1:0]     ev_time;
  logic [VOLT_BITS-1:0]  ev_volt;
  logic [VOLT_BITS-1:0]  ev_ref;
  logic [NUM_SHUNTS-1:0] run_vec;
  logic [NUM_SHUNTS-1:0] mask_ext;

  // scan state
  logic [CNT_W-1:0] scan_pos;
  logic [CNT_W-1:0] scan_lim;
  logic [IDX_W-1:0] scan_idx;
  logic             found;
  logic [IDX_W-1:0] sel_idx;
  logic             sel_up;

  // timers
  logic [TIME_W-1:0] up_start;
  logic              up_active;
  logic [TIME_W-1:0] down_start;
  logic              down_active;
  logic [TIME_W-1:0] last_time;
  logic              last_valid;

  // scan compare
  logic [CMP_W-1:0]  volt_x, ref_x, band_x;
  logic              scan_end, v_low, v_high;
  logic [SECT_W-1:0] cur_sec;
  logic              can_up, can_down, react, bank_hit, bank_up;

  // commit terms
  logic              up_due, down_due, move_due, same_time, do_step;
  logic [SECT_W-1:0] sel_sec, stepped;

  // mask bits beyond the field count as not running
  for (genvar g = 0; g < NUM_SHUNTS; g++) begin : g_mask
    if (g < MASK_BITS) begin : g_in
      assign mask_ext[g] = running_mask[g];
    end else begin : g_out
      assign mask_ext[g] = 1'b0;
    end
  end

  // clamp active count to the table depth
  assign scan_lim = (32'(active_shunts) > NUM_SHUNTS) ? CNT_W'(NUM_SHUNTS)
                                                      : CNT_W'(active_shunts);
  assign scan_idx = scan_pos[IDX_W-1:0];
  assign scan_end = (scan_pos >= scan_lim);

  // test one bank against the dead band and its limits
  always_comb begin
    volt_x   = CMP_W'(ev_volt);
    ref_x    = CMP_W'(ev_ref);
    band_x   = CMP_W'(band_table[scan_idx]);
    v_low    = (volt_x + band_x) < ref_x;
    v_high   = volt_x > (ref_x + band_x);
    cur_sec  = section_count[scan_idx];
    can_up   = cur_sec < max_table[scan_idx];
    can_down = cur_sec > min_table[scan_idx];
    react    = reactor_flags[scan_idx];
    bank_up  = v_low ? !react : react;
    bank_hit = run_vec[scan_idx] &&
               ((v_low && (react ? can_down : can_up)) ||
                (!v_low && v_high && (react ? can_up : can_down)));
  end

  assign status.scan_stop = scan_end || bank_hit;
  assign status.out_free  = !out_valid || !out_stall;

  // due test, repeated time stamp, section step
  always_comb begin
    up_due    = !up_active || ((ev_time - up_start) >= TIME_W'(step_delay));
    down_due  = !down_active || ((ev_time - down_start) >= TIME_W'(step_delay));
    move_due  = found && (sel_up ? up_due : down_due);
    same_time = last_valid && (last_time == ev_time);
    do_step   = move_due && !same_time;
    sel_sec   = section_count[sel_idx];
    stepped   = sel_up ? sel_sec + SECT_W'(1) : sel_sec - SECT_W'(1);
  end

  // table writes: load beats and committed steps
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SHUNTS; i++) begin
      if (cmd.load && (32'(shunt_index) == i)) begin
        min_table[i]     <= section_min;
        max_table[i]     <= section_max;
        section_count[i] <= section_start;
        band_table[i]    <= dead_band;
        reactor_flags[i] <= is_reactor;
      end else if (cmd.commit && do_step && (32'(sel_idx) == i)) begin
        section_count[i] <= stepped;
      end
    end
  end

  // evaluate beat latch
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ev_time <= time_now;
      ev_volt <= voltage;
      ev_ref  <= voltage_ref;
      run_vec <= mask_ext;
    end
  end

  // scan walk
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos <= '0;
      found    <= 1'b0;
    end else if (cmd.start) begin
      scan_pos <= '0;
      found    <= 1'b0;
    end else if (cmd.scan && !scan_end) begin
      if (bank_hit) begin
        found <= 1'b1;
      end else begin
        scan_pos <= scan_pos + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && !scan_end && bank_hit) begin
      sel_idx <= scan_idx;
      sel_up  <= bank_up;
    end
  end

  // direction timers and last step stamp
  always_ff @(posedge clk) begin
    if (rst) begin
      up_start    <= '0;
      up_active   <= 1'b0;
      down_start  <= '0;
      down_active <= 1'b0;
      last_time   <= '0;
      last_valid  <= 1'b0;
    end else if (cmd.commit && move_due) begin
      if (sel_up) begin
        up_start    <= ev_time;
        up_active   <= 1'b1;
        down_start  <= '0;
        down_active <= 1'b0;
      end else begin
        down_start  <= ev_time;
        down_active <= 1'b1;
        up_start    <= '0;
        up_active   <= 1'b0;
      end
      if (!same_time) begin
        last_time  <= ev_time;
        last_valid <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (do_step) begin
        step_kind   <= sel_up ? KIND_UP : KIND_DOWN;
        step_shunt  <= SHUNT_W'(sel_idx);
        new_section <= stepped;
      end else begin
        step_kind   <= KIND_NONE;
        step_shunt  <= '0;
        new_section <= '0;
      end
    end
  end

endmodule

// File: bench/shunt_bank_voltage_stepper_core_tb.sv
// ----------------------------------------------------------------------------
// shunt_bank_voltage_stepper_core_tb
// Self-checking bench for the shunt bank voltage stepper. Bank loads and
// voltage evaluations are driven over valid/stall with random gaps. A
// scoreboard mirrors the bank tables, both direction timers and the last step
// stamp to predict each step result. The sink stalls at random. Registers are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module shunt_bank_voltage_stepper_core_tb;
  import sbvs_pkg::*;

  localparam int NUM_SHUNTS    = DEF_NUM_SHUNTS;
  localparam int VOLT_BITS     = DEF_VOLT_BITS;
  localparam int SETTLE_CYCLES = NUM_SHUNTS + 6;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASES        = 6;
  localparam int PHASE_BEATS   = 65;
  localparam int UNITY         = 16384;  // 1.0 per unit in Q2.14

  // one input beat, field per port
  typedef struct packed {
    logic                 action;
    logic [SHUNT_W-1:0]   index;
    logic [SECT_W-1:0]    lo;
    logic [SECT_W-1:0]    hi;
    logic [SECT_W-1:0]    start;
    logic [BAND_W-1:0]    band;
    logic                 reactor;
    logic [TIME_W-1:0]    stamp;
    logic [VOLT_BITS-1:0] volt;
    logic [VOLT_BITS-1:0] vref;
    logic [MASK_BITS-1:0] mask;
  } beat_t;

  // one step result
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SHUNT_W-1:0] shunt;
    logic [SECT_W-1:0]  sect;
  } step_t;

  // Mirrors bank tables, timers and registers; queues the predicted steps.
  class stepper_scoreboard;
    logic [SECT_W-1:0]   sect_now [NUM_SHUNTS];
    logic [SECT_W-1:0]   sect_lo  [NUM_SHUNTS];
    logic [SECT_W-1:0]   sect_hi  [NUM_SHUNTS];
    logic [BAND_W-1:0]   band     [NUM_SHUNTS];
    logic                reactor  [NUM_SHUNTS];
    logic [TIME_W-1:0]   up_since;
    logic [TIME_W-1:0]   down_since;
    logic [TIME_W-1:0]   last_step_at;
    logic                up_running;
    logic                down_running;
    logic                stepped_once;
    logic [DELAY_W-1:0]  delay_ticks;
    logic [ACTIVE_W-1:0] bank_count;
    step_t               expected_steps [$];
    int                  errors;

    function new();
      up_since     = '0;
      down_since   = '0;
      last_step_at = '0;
      up_running   = 1'b0;
      down_running = 1'b0;
      stepped_once = 1'b0;
      delay_ticks  = DELAY_RESET;
      bank_count   = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic idx, logic [PDATA_W-1:0] value);
      if (idx == REG_STEP_DELAY) begin
        delay_ticks = value[DELAY_W-1:0];
      end else begin
        bank_count = value[ACTIVE_W-1:0];
      end
    endfunction

    function int pending();
      return expected_steps.size();
    endfunction

    function void note_input(beat_t b);
      int                v;
      int                r;
      int                band_w;
      int                n;
      int                s;
      int                pick;
      logic              go_up;
      logic              due;
      logic              below;
      logic              above;
      logic [TIME_W-1:0] since;
      step_t             res;
      if (b.action == ACT_LOAD) begin
        sect_lo[b.index]  = b.lo;
        sect_hi[b.index]  = b.hi;
        sect_now[b.index] = b.start;
        band[b.index]     = b.band;
        reactor[b.index]  = b.reactor;
        return;
      end
      v     = b.volt;
      r     = b.vref;
      n     = (bank_count > NUM_SHUNTS) ? NUM_SHUNTS : bank_count;
      pick  = -1;
      go_up = 1'b0;
      // first running bank outside its band that can still move
      for (s = 0; s < n && pick < 0; s++) begin
        if (!b.mask[s]) continue;
        band_w = band[s];
        below  = v < r - band_w;
        above  = v > r + band_w;
        if (below && (reactor[s] ? sect_now[s] > sect_lo[s] : sect_now[s] < sect_hi[s])) begin
          pick  = s;
          go_up = !reactor[s];
        end else if (above &&
                     (reactor[s] ? sect_now[s] < sect_hi[s] : sect_now[s] > sect_lo[s])) begin
          pick  = s;
          go_up = reactor[s];
        end
      end
      res.kind  = KIND_NONE;
      res.shunt = '0;
      res.sect  = '0;
      if (pick >= 0) begin
        since = b.stamp - (go_up ? up_since : down_since);
        due   = go_up ? (!up_running || since >= delay_ticks)
                      : (!down_running || since >= delay_ticks);
        if (due) begin
          // a due move restarts its own timer and idles the other
          if (go_up) begin
            up_since     = b.stamp;
            up_running   = 1'b1;
            down_since   = '0;
            down_running = 1'b0;
          end else begin
            down_since   = b.stamp;
            down_running = 1'b1;
            up_since     = '0;
            up_running   = 1'b0;
          end
          // no second step at the same time stamp
          if (!(stepped_once && last_step_at == b.stamp)) begin
            sect_now[pick] = go_up ? sect_now[pick] + 1'b1 : sect_now[pick] - 1'b1;
            last_step_at   = b.stamp;
            stepped_once   = 1'b1;
            res.kind       = go_up ? KIND_UP : KIND_DOWN;
            res.shunt      = pick[SHUNT_W-1:0];
            res.sect       = sect_now[pick];
          end
        end
      end
      expected_steps = {expected_steps, res};
    endfunction

    task check_result(step_t got);
      step_t want;
      if (expected_steps.size() == 0) begin
        report($sformatf("unexpected step kind %0d bank %0d section %0d",
                         got.kind, got.shunt, got.sect));
        return;
      end
      want = expected_steps.pop_front();
      if (got.kind !== want.kind || got.shunt !== want.shunt || got.sect !== want.sect) begin
        report($sformatf("step got kind %0d bank %0d section %0d, want %0d %0d %0d",
                         got.kind, got.shunt, got.sect, want.kind, want.shunt, want.sect));
      end
    endtask

    task report(string msg);
      errors++;
      if (errors <= 40) begin
        $display("mismatch: %s", msg);
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_stall;
  logic                 action;
  logic [SHUNT_W-1:0]   shunt_index;
  logic [SECT_W-1:0]    section_min;
  logic [SECT_W-1:0]    section_max;
  logic [SECT_W-1:0]    section_start;
  logic [BAND_W-1:0]    dead_band;
  logic                 is_reactor;
  logic [TIME_W-1:0]    time_now;
  logic [VOLT_BITS-1:0] voltage;
  logic [VOLT_BITS-1:0] voltage_ref;
  logic [MASK_BITS-1:0] running_mask;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KIND_W-1:0]    step_kind;
  logic [SHUNT_W-1:0]   step_shunt;
  logic [SECT_W-1:0]    new_section;

  stepper_scoreboard sb;
  logic [TIME_W-1:0] time_cursor;
  int                cur_delay;
  logic              calm;
  int                stall_left;
  int                quiet;

  shunt_bank_voltage_stepper_core u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .shunt_index  (shunt_index),
    .section_min  (section_min),
    .section_max  (section_max),
    .section_start(section_start),
    .dead_band    (dead_band),
    .is_reactor   (is_reactor),
    .time_now     (time_now),
    .voltage      (voltage),
    .voltage_ref  (voltage_ref),
    .running_mask (running_mask),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .step_kind    (step_kind),
    .step_shunt   (step_shunt),
    .new_section  (new_section)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // beat with every field random; callers override what matters
  function automatic beat_t noise_beat();
    logic [127:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom};
    return noise[$bits(beat_t)-1:0];
  endfunction

  function automatic beat_t load_beat(int idx, int lo, int hi, int start, int band_w,
                                      logic reactor_bank);
    beat_t b;
    b         = noise_beat();
    b.action  = ACT_LOAD;
    b.index   = SHUNT_W'(idx);
    b.lo      = SECT_W'(lo);
    b.hi      = SECT_W'(hi);
    b.start   = SECT_W'(start);
    b.band    = BAND_W'(band_w);
    b.reactor = reactor_bank;
    return b;
  endfunction

  function automatic beat_t eval_beat(logic [TIME_W-1:0] stamp, int volt, int vref,
                                      logic [MASK_BITS-1:0] mask);
    beat_t b;
    b        = noise_beat();
    b.action = ACT_EVAL;
    b.stamp  = stamp;
    b.volt   = VOLT_BITS'(volt);
    b.vref   = VOLT_BITS'(vref);
    b.mask   = mask;
    return b;
  endfunction

  // Random beat: mostly evaluations near 1.0 pu with a moving clock,
  // some bank reloads, and a share of wild values.
  function automatic beat_t random_beat();
    beat_t b;
    int    r;
    int    lo;
    int    hi;
    int    vref;
    int    volt;
    b = noise_beat();
    r = $urandom_range(0, 99);
    if (r < 15) begin
      b.action = ACT_LOAD;
      b.index  = SHUNT_W'($urandom_range(0, NUM_SHUNTS - 1));
      if ($urandom_range(0, 9) >= 2) begin
        lo      = $urandom_range(0, 100);
        hi      = lo + $urandom_range(0, 150);
        b.lo    = SECT_W'(lo);
        b.hi    = SECT_W'(hi);
        b.start = SECT_W'($urandom_range(lo, hi));
      end
      if ($urandom_range(0, 9) != 0) b.band = BAND_W'($urandom_range(0, 400));
      return b;
    end
    b.action = ACT_EVAL;
    // clock: repeats, steps back, jumps, or moves around the delay
    r = $urandom_range(0, 99);
    if (r < 8) begin
      time_cursor = time_cursor;
    end else if (r < 13) begin
      time_cursor = time_cursor - TIME_W'($urandom_range(1, 60));
    end else if (r < 18) begin
      time_cursor = $urandom;
    end else if (r < 55) begin
      time_cursor = time_cursor + TIME_W'($urandom_range(1, 12));
    end else begin
      time_cursor = time_cursor + TIME_W'($urandom_range(1, cur_delay + cur_delay / 4 + 2));
    end
    b.stamp = time_cursor;
    if ($urandom_range(0, 4) != 0) begin
      b.vref = VOLT_BITS'(UNITY + $urandom_range(0, 2000) - 1000);
    end
    vref = b.vref;
    if ($urandom_range(0, 6) != 0) begin
      volt = vref + $urandom_range(0, 1200) - 600;
      if (volt < 0) volt = 0;
      if (volt > 65535) volt = 65535;
      b.volt = VOLT_BITS'(volt);
    end
    if ($urandom_range(0, 9) < 6) b.mask = '1;
    return b;
  endfunction

  // drive one beat and hold it until it is taken
  task automatic send(beat_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= b.action;
    shunt_index   <= b.index;
    section_min   <= b.lo;
    section_max   <= b.hi;
    section_start <= b.start;
    dead_band     <= b.band;
    is_reactor    <= b.reactor;
    time_now      <= b.stamp;
    voltage       <= b.volt;
    voltage_ref   <= b.vref;
    running_mask  <= b.mask;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_input(b);
  endtask

  // stop sending and wait for every predicted step
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // fully idle: no result owed and the last beat worked off
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write: setup then access phase
  task automatic write_reg(logic idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  // sink: check accepted beats, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) sb.check_result({step_kind, step_shunt, new_section});
      if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: too long without a beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet++;
    end
  end

  initial begin
    int                 p;
    int                 k;
    logic [DELAY_W-1:0] d;
    logic [ACTIVE_W-1:0] a;
    sb            = new();
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    action        = ACT_LOAD;
    shunt_index   = '0;
    section_min   = '0;
    section_max   = '0;
    section_start = '0;
    dead_band     = '0;
    is_reactor    = 1'b0;
    time_now      = '0;
    voltage       = '0;
    voltage_ref   = '0;
    running_mask  = '0;
    calm          = 1'b0;
    quiet         = 0;
    stall_left    = 0;
    time_cursor   = '0;
    cur_delay     = DELAY_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: no bank scanned yet, delay 10
    send(eval_beat(32'd7, 0, 65535, 8'hFF));
    send(load_beat(0, 0, 255, 0, 0, 1'b0));
    send(load_beat(1, 0, 255, 255, 16383, 1'b1));
    send(load_beat(2, 200, 100, 250, 100, 1'b0));   // inverted limits
    send(load_beat(3, 5, 5, 5, 0, 1'b0));           // stuck bank
    send(load_beat(4, 10, 20, 15, 50, 1'b1));
    send(load_beat(5, 0, 3, 1, 8191, 1'b0));
    send(load_beat(6, 0, 0, 0, 0, 1'b1));
    send(load_beat(7, 1, 254, 127, 1, 1'b0));
    settle();
    write_reg(REG_ACTIVE_SHUNTS, 32'd8);

    // timer pacing, repeated and backward stamps, mask and extremes
    send(eval_beat(32'd100, UNITY - 1, UNITY, 8'hFF));
    send(eval_beat(32'd105, UNITY - 1, UNITY, 8'hFF));
    send(eval_beat(32'd110, UNITY - 1, UNITY, 8'hFF));
    send(eval_beat(32'd110, UNITY + 1, UNITY, 8'hFF));
    send(eval_beat(32'd111, UNITY + 1, UNITY, 8'hFF));
    send(eval_beat(32'd50, UNITY + 1, UNITY, 8'hFF));
    send(eval_beat(32'd60, 10000, 40000, 8'hFE));
    send(eval_beat(32'd61, 0, 65535, 8'h00));
    send(eval_beat(32'hFFFF_FFFF, 0, 65535, 8'hFF));
    send(eval_beat(32'd0, 65535, 0, 8'hFF));
    send(eval_beat(32'd20, UNITY + 102, UNITY, 8'h04));
    send(eval_beat(32'd30, UNITY + 2, UNITY, 8'h80));

    // random phases, each under its own register setting
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin d = 16'd0;     a = 4'd8;  end
        1: begin d = 16'hFFFF;  a = 4'd15; end
        2: begin d = 16'd3;     a = 4'd4;  end
        3: begin d = DELAY_W'($urandom_range(0, 40));  a = 4'd1; end
        4: begin d = DELAY_W'($urandom_range(0, 300)); a = ACTIVE_W'($urandom_range(0, 15)); end
        default: begin d = 16'd20; a = 4'd9; end
      endcase
      settle();
      write_reg(REG_STEP_DELAY, PDATA_W'(d));
      write_reg(REG_ACTIVE_SHUNTS, PDATA_W'(a));
      cur_delay = d;
      calm      = (p == 2);
      for (k = 0; k < PHASE_BEATS; k++) begin
        send(random_beat());
        // hold off once until every step has come back
        if (p == 1 && k == PHASE_BEATS / 2) drain();
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
